/* hw/rtl/opwm_pkg.sv */
// ---------------------------------------------------------------------------
// opwm_pkg
// Shared constants and types of the order-preserving window matcher.
// ---------------------------------------------------------------------------
package opwm_pkg;

   localparam int MAX_PATTERN_DEF = 16;
   localparam int INDEX_WIDTH_DEF = 16;

   localparam int SAMPLE_W   = 32;
   localparam int LEN_CFG_W  = 5;
   localparam int ORDER_W    = 64;
   localparam int NIBBLE_W   = 4;
   localparam int COUNT_W    = 16;
   localparam int START_W    = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   localparam logic [LEN_CFG_W-1:0] LEN_RESET     = LEN_CFG_W'(2);
   localparam logic [LEN_CFG_W-1:0] LEN_MIN       = LEN_CFG_W'(2);
   localparam logic [COUNT_W-1:0]   SUPPORT_RESET = COUNT_W'(12);
   localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_ORDER_TABLE    = 2'd1,
      CSR_MIN_SUPPORT    = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_addr_type;

   // stage-1 item info handed from the window to the result stage
   typedef struct packed {
      logic               last;
      logic               full;
      logic [START_W-1:0] start;
   } stage_info_type;

endpackage

/* hw/rtl/opwm_window.sv */
// ---------------------------------------------------------------------------
// opwm_window
// Sample shift register, fill count and sample index; input stage register.
// ---------------------------------------------------------------------------
module opwm_window #(
   parameter int MAX_PATTERN = opwm_pkg::MAX_PATTERN_DEF,
   parameter int INDEX_WIDTH = opwm_pkg::INDEX_WIDTH_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                in_fire,
   input  logic                                                advance,
   input  logic [opwm_pkg::SAMPLE_W-1:0]                       sample,
   input  logic                                                last,
   input  logic [opwm_pkg::LEN_CFG_W-1:0]                      eff_len,
   output logic                                                stage_valid,
   output opwm_pkg::stage_info_type                            stage_info,
   output logic [MAX_PATTERN-1:0][opwm_pkg::SAMPLE_W-1:0]      window
);

   localparam int FILL_W = $clog2(MAX_PATTERN + 1);
   localparam int WIDE_W = (INDEX_WIDTH > opwm_pkg::START_W) ? INDEX_WIDTH
                                                             : opwm_pkg::START_W;

   logic [MAX_PATTERN-1:0][opwm_pkg::SAMPLE_W-1:0] window_ff;
   logic [FILL_W-1:0]                              fill_ff, fill_in;
   logic [INDEX_WIDTH-1:0]                         index_ff, start_idx;
   logic [WIDE_W-1:0]                              start_wide;
   logic                                           valid_ff, valid_in;
   opwm_pkg::stage_info_type                       info_ff, info_in;

   always_comb begin
      fill_in = (fill_ff == FILL_W'(MAX_PATTERN)) ? fill_ff : fill_ff + FILL_W'(1);
      start_idx = index_ff - INDEX_WIDTH'(eff_len - opwm_pkg::LEN_CFG_W'(1));
      start_wide = WIDE_W'(start_idx);
      info_in.last = last;
      info_in.full = (opwm_pkg::LEN_CFG_W'(fill_in) >= eff_len);
      info_in.start = info_in.full ? start_wide[opwm_pkg::START_W-1:0] : '0;
      valid_in = in_fire ? 1'b1 : (advance ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (in_fire) begin
            fill_ff <= last ? '0 : fill_in;
            index_ff <= last ? '0 : index_ff + INDEX_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         window_ff <= {window_ff[MAX_PATTERN-2:0], sample};
         info_ff <= info_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_info  = info_ff;
   assign window      = window_ff;

endmodule

/* hw/rtl/opwm_match.sv */
// ---------------------------------------------------------------------------
// opwm_match
// Parallel rank-order check of the current window against the order table.
// ---------------------------------------------------------------------------
module opwm_match #(
   parameter int MAX_PATTERN = opwm_pkg::MAX_PATTERN_DEF
) (
   input  logic [MAX_PATTERN-1:0][opwm_pkg::SAMPLE_W-1:0] window,
   input  logic [opwm_pkg::ORDER_W-1:0]                   order_table,
   input  logic [opwm_pkg::LEN_CFG_W-1:0]                 eff_len,
   output logic                                           match
);

   localparam int SEL_W = $clog2(MAX_PATTERN);
   localparam int LW    = opwm_pkg::LEN_CFG_W;

   logic [MAX_PATTERN-2:0] pair_ok;

   always_comb begin
      for (int k = 0; k < MAX_PATTERN - 1; k++) begin
         logic [LW-1:0]    a, b, pa, pb;
         logic [SEL_W-1:0] sa, sb;
         a  = LW'(order_table[k*opwm_pkg::NIBBLE_W +: opwm_pkg::NIBBLE_W]);
         b  = LW'(order_table[(k+1)*opwm_pkg::NIBBLE_W +: opwm_pkg::NIBBLE_W]);
         pa = eff_len - LW'(1) - a;
         pb = eff_len - LW'(1) - b;
         sa = pa[SEL_W-1:0];
         sb = pb[SEL_W-1:0];
         if (LW'(k + 1) >= eff_len) begin
            pair_ok[k] = 1'b1;
         end else if (a >= eff_len || b >= eff_len) begin
            pair_ok[k] = 1'b0;
         end else begin
            pair_ok[k] = $signed(window[sa]) < $signed(window[sb]);
         end
      end
   end

   assign match = &pair_ok;

endmodule

/* hw/rtl/order_preserving_window_matcher.sv */
// ---------------------------------------------------------------------------
// order_preserving_window_matcher
// Streams series samples and flags windows whose rank order fits a pattern.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one signed Q16.16 sample per word; req_tlast ends a
//   sequence. rsp_* returns one word per sample: match flag, window start
//   index, running match count and, on the last word, the frequent flag.
//   csr_* writes pattern_length (0), order_table (1), min_support (2);
//   write only while no words are in flight.
// Pipeline: a sample enters the input stage register when it is accepted
//   and moves to the result register when that stage advances.
// Throughput: one sample per cycle while rsp_tready stays high; the window
//   compares are all parallel muxes and comparators between the two registers.
// Reset: synchronous; clears counters, fill state and both stages, and
//   loads pattern_length 2, order_table 0, min_support 12.
// Stall: while rsp_tready is low the result holds; req_tready drops only
//   when both stages hold a word.
// ---------------------------------------------------------------------------
module order_preserving_window_matcher #(
   parameter int MAX_PATTERN = opwm_pkg::MAX_PATTERN_DEF,
   parameter int INDEX_WIDTH = opwm_pkg::INDEX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [opwm_pkg::SAMPLE_W-1:0]     req_tdata,  // [31:0] sample
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] window_match, [16:1] match_start, [32:17] match_total,
   // [33] frequent, [39:34] zero
   output logic [opwm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [opwm_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [opwm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int LW = opwm_pkg::LEN_CFG_W;
   localparam int CW = opwm_pkg::COUNT_W;

   logic [LW-1:0]                  len_ff, eff_len;
   logic [opwm_pkg::ORDER_W-1:0]   order_ff;
   logic [CW-1:0]                  support_ff;
   logic [CW-1:0]                  count_ff, count_in;

   logic                           out_valid_ff;
   logic                           match_out_ff, frequent_ff, last_out_ff;
   logic [opwm_pkg::START_W-1:0]   start_ff;
   logic [CW-1:0]                  total_ff;

   logic                           in_fire, advance, stage_valid, match, hit;
   opwm_pkg::stage_info_type       stage_info;
   logic [MAX_PATTERN-1:0][opwm_pkg::SAMPLE_W-1:0] window;

   always_comb begin
      if (len_ff < opwm_pkg::LEN_MIN) begin
         eff_len = opwm_pkg::LEN_MIN;
      end else if (len_ff > LW'(MAX_PATTERN)) begin
         eff_len = LW'(MAX_PATTERN);
      end else begin
         eff_len = len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= opwm_pkg::LEN_RESET;
         order_ff <= '0;
         support_ff <= opwm_pkg::SUPPORT_RESET;
      end else if (csr_we) begin
         unique case (opwm_pkg::csr_addr_type'(csr_addr))
            opwm_pkg::CSR_PATTERN_LENGTH: len_ff <= csr_wdata[LW-1:0];
            opwm_pkg::CSR_ORDER_TABLE:    order_ff <= csr_wdata;
            opwm_pkg::CSR_MIN_SUPPORT:    support_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   assign advance    = stage_valid && (!out_valid_ff || rsp_tready);
   assign req_tready = !stage_valid || advance;
   assign in_fire    = req_tvalid && req_tready;

   opwm_window #(
      .MAX_PATTERN(MAX_PATTERN),
      .INDEX_WIDTH(INDEX_WIDTH)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .advance     (advance),
      .sample      (req_tdata),
      .last        (req_tlast),
      .eff_len     (eff_len),
      .stage_valid (stage_valid),
      .stage_info  (stage_info),
      .window      (window)
   );

   opwm_match #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_match (
      .window      (window),
      .order_table (order_ff),
      .eff_len     (eff_len),
      .match       (match)
   );

   always_comb begin
      hit = stage_info.full && match;
      count_in = (hit && count_ff != opwm_pkg::COUNT_MAX) ? count_ff + CW'(1) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            count_ff <= stage_info.last ? '0 : count_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         match_out_ff <= hit;
         start_ff <= stage_info.start;
         total_ff <= count_in;
         frequent_ff <= stage_info.last && (count_in >= support_ff);
         last_out_ff <= stage_info.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = last_out_ff;
   assign rsp_tdata  = {6'd0, frequent_ff, total_ff, start_ff, match_out_ff};

`ifndef SYNTH
   a_frequent_on_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && frequent_ff |-> last_out_ff)
      else $error("frequent flag without last");

   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && match_out_ff |-> total_ff != '0)
      else $error("match reported with zero total");

   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      advance && stage_info.last |=> count_ff == '0)
      else $error("match count not cleared after last");

   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> out_valid_ff && !rsp_tready)
      else $error("input stalled without output backpressure");
`endif

endmodule

/* sim/tb_order_preserving_window_matcher.sv */
// ---------------------------------------------------------------------------
// tb_order_preserving_window_matcher
// Streams signed samples through the matcher and checks every result word
// against a cycle-free prediction of window rank matching, start index,
// saturating match count and the frequent flag. Runs directed corner
// sequences, randomized phases over several register settings, and one
// long rising sequence.
// ---------------------------------------------------------------------------
module tb_order_preserving_window_matcher;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int IDLE_PCT       = 22;
   localparam int WIN_DEPTH      = opwm_pkg::MAX_PATTERN_DEF;

   typedef struct packed {
      logic [opwm_pkg::SAMPLE_W-1:0] sample;
      logic                          last;
   } sample_word_type;

   typedef struct packed {
      logic                         hit;
      logic [opwm_pkg::START_W-1:0] start;
      logic [opwm_pkg::COUNT_W-1:0] total;
      logic                         freq;
      logic                         last;
   } match_result_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [opwm_pkg::SAMPLE_W-1:0]   req_tdata  = '0;   // [31:0] sample
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // [0] window_match, [16:1] match_start, [32:17] match_total,
   // [33] frequent, [39:34] zero
   logic [opwm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_we     = 1'b0;
   logic [opwm_pkg::CSR_ADDR_W-1:0] csr_addr   = opwm_pkg::CSR_PATTERN_LENGTH;
   logic [opwm_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   sample_word_type  sample_queue[$];
   match_result_type predicted_words[$];
   int               words_queued  = 0;
   int               results_seen  = 0;
   int               mismatches    = 0;
   int               stall_cycles  = 0;
   logic             word_taken    = 1'b0;
   logic             steady        = 1'b0;

   // predictor state and register copies
   logic [opwm_pkg::LEN_CFG_W-1:0]       len_cfg     = opwm_pkg::LEN_RESET;
   logic [opwm_pkg::ORDER_W-1:0]         order_cfg   = '0;
   logic [opwm_pkg::COUNT_W-1:0]         support_cfg = opwm_pkg::SUPPORT_RESET;
   logic signed [opwm_pkg::SAMPLE_W-1:0] window_hist [WIN_DEPTH];
   logic [15:0]                          seq_index;
   logic [opwm_pkg::COUNT_W-1:0]         match_count;
   int                                   fill_level;

   order_preserving_window_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int span();
      if (len_cfg < opwm_pkg::LEN_MIN) return 2;
      if (len_cfg > WIN_DEPTH) return WIN_DEPTH;
      return int'(len_cfg);
   endfunction

   function automatic match_result_type advance_window(logic [opwm_pkg::SAMPLE_W-1:0] smp,
                                                       logic lst);
      match_result_type r;
      int               n;
      int               a;
      int               b;
      logic             ok;
      n = span();
      for (int i = WIN_DEPTH - 1; i > 0; i--) window_hist[i] = window_hist[i-1];
      window_hist[0] = smp;
      if (fill_level < WIN_DEPTH) fill_level++;
      r = '0;
      if (fill_level >= n) begin
         r.start = seq_index - 16'(n - 1);
         ok = 1'b1;
         for (int k = 0; k + 1 < n; k++) begin
            a = int'(order_cfg[4*k +: 4]);
            b = int'(order_cfg[4*(k+1) +: 4]);
            if (a >= n || b >= n) ok = 1'b0;
            else if (!(window_hist[n-1-a] < window_hist[n-1-b])) ok = 1'b0;
         end
         r.hit = ok;
         if (ok && match_count != opwm_pkg::COUNT_MAX) match_count++;
      end
      r.total = match_count;
      r.freq  = lst && (match_count >= support_cfg);
      r.last  = lst;
      seq_index++;
      if (lst) begin
         seq_index   = '0;
         match_count = '0;
         fill_level  = 0;
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // driver: new words and ready change on the falling edge
   always @(negedge clock) begin
      sample_word_type               w;
      logic                          nv;
      logic [opwm_pkg::SAMPLE_W-1:0] nd;
      logic                          nl;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         nv = req_tvalid;
         nd = req_tdata;
         nl = req_tlast;
         if (!req_tvalid || word_taken) begin
            nv = 1'b0;
            if (sample_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               w  = sample_queue.pop_front();
               nv = 1'b1;
               nd = w.sample;
               nl = w.last;
            end
         end
         req_tvalid <= nv;
         req_tdata  <= nd;
         req_tlast  <= nl;
         rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // monitor: predict on accepted samples, check accepted results
   always @(posedge clock) begin
      match_result_type want;
      match_result_type got;
      if (reset) begin
         word_taken   = 1'b0;
         stall_cycles = 0;
         window_hist  = '{default: '0};
         seq_index    = '0;
         match_count  = '0;
         fill_level   = 0;
         len_cfg      = opwm_pkg::LEN_RESET;
         order_cfg    = '0;
         support_cfg  = opwm_pkg::SUPPORT_RESET;
      end else begin
         word_taken = req_tvalid && req_tready;
         if (word_taken) predicted_words.push_back(advance_window(req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.hit   = rsp_tdata[0];
            got.start = rsp_tdata[16:1];
            got.total = rsp_tdata[32:17];
            got.freq  = rsp_tdata[33];
            got.last  = rsp_tlast;
            if (predicted_words.size() == 0) begin
               $error("result word with no sample outstanding");
               mismatches++;
            end else begin
               want = predicted_words.pop_front();
               check_field("window_match", want.hit, got.hit);
               check_field("match_start", want.start, got.start);
               check_field("match_total", want.total, got.total);
               check_field("frequent", want.freq, got.freq);
               check_field("last_out", want.last, got.last);
               check_field("pad", 0, rsp_tdata[39:34]);
            end
         end
         if (word_taken || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic write_csr(opwm_pkg::csr_addr_type idx,
                            logic [opwm_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = val;
      case (idx)
         opwm_pkg::CSR_PATTERN_LENGTH: len_cfg = val[opwm_pkg::LEN_CFG_W-1:0];
         opwm_pkg::CSR_ORDER_TABLE:    order_cfg = val;
         opwm_pkg::CSR_MIN_SUPPORT:    support_cfg = val[opwm_pkg::COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic queue_word(logic [opwm_pkg::SAMPLE_W-1:0] s, logic l);
      sample_word_type w;
      w.sample = s;
      w.last   = l;
      sample_queue.push_back(w);
      words_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (results_seen != words_queued);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [opwm_pkg::SAMPLE_W-1:0] noise_sample();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 6) - 3;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // mix of rank-ordered blocks that fit the current table and loose samples
   task automatic queue_sequence(int len);
      logic [opwm_pkg::SAMPLE_W-1:0]        ramp [WIN_DEPTH];
      logic signed [opwm_pkg::SAMPLE_W-1:0] lvl;
      logic [31:0]                          gap_max;
      int                                   n;
      int                                   pos;
      int                                   off;
      n   = span();
      pos = 0;
      while (pos < len) begin
         if (len - pos >= n && $urandom_range(0, 99) < 60) begin
            lvl     = $signed($urandom()) >>> 1;
            gap_max = ($urandom_range(0, 1) != 0) ? 32'd3 : 32'h0400_0000;
            for (int k = 0; k < WIN_DEPTH; k++) ramp[k] = noise_sample();
            for (int k = 0; k < n; k++) begin
               off = int'(order_cfg[4*k +: 4]);
               if (off < n) ramp[off] = lvl;
               lvl = lvl + $signed($urandom_range(1, gap_max));
            end
            for (int k = 0; k < n; k++) begin
               queue_word(ramp[k], pos == len - 1);
               pos++;
            end
         end else begin
            queue_word(noise_sample(), pos == len - 1);
            pos++;
         end
      end
   endtask

   initial begin
      logic [opwm_pkg::ORDER_W-1:0]  order;
      logic [3:0]                    perm [WIN_DEPTH];
      logic [3:0]                    tmp;
      logic [opwm_pkg::SAMPLE_W-1:0] climb;
      int                            n;
      int                            j;
      int                            count;
      int                            seq_len;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: all-zero table compares a sample with itself
      @(posedge clock);
      queue_word(32'h7FFF_FFFF, 1'b0);
      queue_word(32'h8000_0000, 1'b1);
      wait_drained();

      // length 2 rising, support 0: extremes, ties, sign crossing
      write_csr(opwm_pkg::CSR_PATTERN_LENGTH, 2);
      write_csr(opwm_pkg::CSR_ORDER_TABLE, 64'h10);
      write_csr(opwm_pkg::CSR_MIN_SUPPORT, 0);
      @(posedge clock);
      queue_word(32'h8000_0000, 1'b0);
      queue_word(32'h7FFF_FFFF, 1'b0);
      queue_word(32'h7FFF_FFFF, 1'b0);
      queue_word(32'h0000_0000, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b0);
      queue_word(32'h0000_0000, 1'b0);
      queue_word(32'h0000_0001, 1'b1);
      queue_word(32'h0000_0005, 1'b1);
      wait_drained();

      // length below range acts as 2, falling order, top support
      write_csr(opwm_pkg::CSR_PATTERN_LENGTH, 0);
      write_csr(opwm_pkg::CSR_ORDER_TABLE, 64'h01);
      write_csr(opwm_pkg::CSR_MIN_SUPPORT, 16'hFFFF);
      @(posedge clock);
      queue_word(32'd10, 1'b0);
      queue_word(32'd5, 1'b0);
      queue_word(32'd3, 1'b1);
      wait_drained();

      // offset past the window end
      write_csr(opwm_pkg::CSR_PATTERN_LENGTH, 1);
      write_csr(opwm_pkg::CSR_ORDER_TABLE, 64'h20);
      @(posedge clock);
      queue_word(32'd1, 1'b0);
      queue_word(32'd2, 1'b0);
      queue_word(32'd3, 1'b1);
      wait_drained();

      // repeated offset
      write_csr(opwm_pkg::CSR_ORDER_TABLE, 64'h11);
      @(posedge clock);
      queue_word(32'd1, 1'b0);
      queue_word(32'd2, 1'b1);
      wait_drained();

      for (int p = 0; p < 10; p++) begin
         case (p)
            0: write_csr(opwm_pkg::CSR_PATTERN_LENGTH, 16);
            1: write_csr(opwm_pkg::CSR_PATTERN_LENGTH, 31);
            2: write_csr(opwm_pkg::CSR_PATTERN_LENGTH, 17);
            3: write_csr(opwm_pkg::CSR_PATTERN_LENGTH, 1);
            default: write_csr(opwm_pkg::CSR_PATTERN_LENGTH, $urandom_range(2, 8));
         endcase
         n = span();
         if (p == 4) begin
            order = '1;
         end else if (p == 5) begin
            order = {$urandom(), $urandom()};
         end else begin
            order = {$urandom(), $urandom()};
            for (int k = 0; k < WIN_DEPTH; k++) perm[k] = 4'(k);
            for (int k = n - 1; k > 0; k--) begin
               j       = $urandom_range(0, k);
               tmp     = perm[k];
               perm[k] = perm[j];
               perm[j] = tmp;
            end
            for (int k = 0; k < n; k++) order[4*k +: 4] = perm[k];
         end
         write_csr(opwm_pkg::CSR_ORDER_TABLE, order);
         case (p)
            0: write_csr(opwm_pkg::CSR_MIN_SUPPORT, 0);
            1: write_csr(opwm_pkg::CSR_MIN_SUPPORT, 16'hFFFF);
            6: write_csr(opwm_pkg::CSR_MIN_SUPPORT, $urandom_range(0, 65535));
            default: write_csr(opwm_pkg::CSR_MIN_SUPPORT, $urandom_range(0, 4));
         endcase
         if (p == 7) write_csr(opwm_pkg::CSR_UNUSED, {$urandom(), $urandom()});
         @(posedge clock);
         steady = (p == 2);
         count  = 0;
         while (count < 25) begin
            seq_len = $urandom_range(1, 3 * n + 4);
            queue_sequence(seq_len);
            count += seq_len;
         end
         wait_drained();
      end

      // one long rising sequence
      write_csr(opwm_pkg::CSR_PATTERN_LENGTH, 2);
      write_csr(opwm_pkg::CSR_ORDER_TABLE, 64'h10);
      write_csr(opwm_pkg::CSR_MIN_SUPPORT, 16'hFFFF);
      @(posedge clock);
      steady = 1'b0;
      for (int i = 0; i < 40; i++) begin
         climb = 32'h8000_0000 + 32'(i) * 32'd32700 + $urandom_range(0, 32699);
         queue_word(climb, i == 39);
      end
      queue_word(32'd1, 1'b0);
      queue_word(32'd2, 1'b0);
      queue_word(32'd3, 1'b1);
      wait_drained();

      repeat (8) @(negedge clock);
      if (mismatches == 0 && predicted_words.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/opwm_pkg.sv
hw/rtl/opwm_window.sv
hw/rtl/opwm_match.sv
hw/rtl/order_preserving_window_matcher.sv
sim/tb_order_preserving_window_matcher.sv
